// File: sv/fpt_pkg.sv
// Shared types and constants for the FIFO paging translator.
package fpt_pkg;

	localparam int UnitBits = 7;
	localparam int AddrBits = 11;
	localparam int PageBits = 3;

	typedef struct packed {
		logic [PageBits-1:0] page_number;
		logic [UnitBits-1:0] unit_offset;
		logic                is_store;
	} in_item_t;

	typedef struct packed {
		logic                page_fault;
		logic [PageBits-1:0] victim_page;
		logic                write_back;
		logic [AddrBits-1:0] physical_address;
	} out_item_t;

	// block a resident page holds after reset
	function automatic int boot_block(input int pg);
		int blk;
		case (pg)
			0:       blk = 5;
			1:       blk = 8;
			2:       blk = 9;
			3:       blk = 1;
			default: blk = pg;
		endcase
		return blk;
	endfunction

endpackage

// File: sv/fpt_table.sv
// Page table, frame ring and translate/replace logic: translation is combinational, the table update is registered.
module fpt_table import fpt_pkg::*; #(
	parameter int PAGES  = 8,
	parameter int FRAMES = 4,
	parameter int BLOCKS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	output out_item_t res
);

	localparam int PW = $clog2(PAGES);
	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int BW = $clog2(BLOCKS);

	logic [PAGES-1:0] present_q;
	logic [PAGES-1:0] dirty_q;
	logic [BW-1:0]    block_q [PAGES];
	logic [PW-1:0]    owner_q [FRAMES];
	logic [FW-1:0]    ptr_q;

	logic          in_range;
	logic [PW-1:0] pg_idx;
	logic [PW-1:0] victim;
	logic          fault;
	logic [BW-1:0] blk_sel;
	logic [FW-1:0] ptr_next;

	assign in_range = (32'(item.page_number) < PAGES);
	assign pg_idx   = PW'(item.page_number);
	assign victim   = owner_q[ptr_q];
	assign fault    = in_range && !present_q[pg_idx];
	assign blk_sel  = fault ? block_q[victim] : block_q[pg_idx];
	assign ptr_next = (32'(ptr_q) == FRAMES - 1) ? '0 : FW'(ptr_q + 1'b1);

	always_comb begin
		res.page_fault       = fault;
		res.victim_page      = fault ? PageBits'(victim) : '0;
		res.write_back       = fault && dirty_q[victim];
		res.physical_address = in_range
			? AddrBits'(AddrBits'(blk_sel) << UnitBits) + AddrBits'(item.unit_offset)
			: '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAGES; i++) begin
				present_q[i] <= (i < FRAMES);
				dirty_q[i]   <= 1'b0;
				block_q[i]   <= (i < FRAMES) ? BW'(boot_block(i) % BLOCKS) : '0;
			end
			for (int f = 0; f < FRAMES; f++) begin
				owner_q[f] <= PW'(f % PAGES);
			end
			ptr_q <= '0;
		end else if (fire && in_range) begin
			if (fault) begin
				// evict first, install second: same page ends up resident
				present_q[victim] <= 1'b0;
				dirty_q[victim]   <= 1'b0;
				block_q[victim]   <= '0;
				owner_q[ptr_q]    <= pg_idx;
				present_q[pg_idx] <= 1'b1;
				block_q[pg_idx]   <= block_q[victim];
				ptr_q             <= ptr_next;
			end
			if (item.is_store) begin
				dirty_q[pg_idx] <= 1'b1;
			end
		end
	end

	a_ptr_only_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && fault) |=> $stable(ptr_q))
		else $error("replacement pointer moved without a fault");

	a_ptr_moves_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		fire && fault |=> (FRAMES == 1) || (ptr_q != $past(ptr_q)))
		else $error("replacement pointer held on a fault");

	a_hit_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!res.page_fault |-> (res.victim_page == '0) && !res.write_back)
		else $error("victim or write-back reported on a hit");

	a_installed: assert property (@(posedge clk) disable iff (!arst_n)
		fire && fault |=> present_q[$past(pg_idx)])
		else $error("faulting page not resident after replacement");

endmodule

// File: sv/fifo_paging_translator.sv
// Top level: input register, translate/replace stage and result register.
// Accepts one access per clock while the output is not stalled, and returns one
// result per access, in order. The access is captured in an input register,
// the page table lookup, FIFO replacement and address formation are done
// combinationally from that register, and the result sits in an output register
// until taken. The page table is read combinationally and updated when the access
// fires, so no access waits on the one before it; a stalled output holds the pipe.
module fifo_paging_translator import fpt_pkg::*; #(
	parameter int PAGES  = 8,
	parameter int FRAMES = 4,
	parameter int BLOCKS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic      v_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      adv;
	logic      fire;
	out_item_t res;

	assign adv      = !out_valid_q || out_ready;
	assign fire     = v_s1 && adv;
	assign in_ready = !v_s1 || adv;

	fpt_table #(
		.PAGES  (PAGES),
		.FRAMES (FRAMES),
		.BLOCKS (BLOCKS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
		if (fire) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(item_s1))
		else $error("input stage dropped a stalled item");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed item did not reach the result register");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 && adv |=> !out_valid_q)
		else $error("result appeared without an item");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for fifo_paging_translator: directed table, then random accesses.
module testbench;
	import fpt_pkg::*;

	localparam int PAGES      = 8;
	localparam int FRAMES     = 4;
	localparam int CYCLE_CAP  = 200000;
	localparam int HOLD_START = 1500;
	localparam int HOLD_LEN   = 400;

	typedef struct {
		in_item_t  acc;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	// page table and frame ring as the block should hold them
	logic       pt_present [PAGES];
	logic [3:0] pt_block   [PAGES];
	logic       pt_dirty   [PAGES];
	logic [2:0] frame_page [FRAMES];
	logic [1:0] fifo_ptr;

	out_item_t translations_due [$];
	stim_row_t stim_table [$];
	int        mismatches;
	int        cycles;
	int        burst_left;
	bit        idle_off;

	fifo_paging_translator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic reset_tables();
		logic [3:0] boot_blk [4];
		boot_blk = '{4'd5, 4'd8, 4'd9, 4'd1};
		for (int i = 0; i < PAGES; i++) begin
			pt_present[i] = 1'b0;
			pt_block[i]   = 4'd0;
			pt_dirty[i]   = 1'b0;
		end
		for (int i = 0; i < FRAMES; i++) begin
			frame_page[i] = 3'(i);
			pt_present[i] = 1'b1;
			pt_block[i]   = boot_blk[i];
		end
		fifo_ptr = 2'd0;
	endtask

	function automatic out_item_t translate_access(in_item_t a);
		out_item_t  r;
		logic [2:0] pg;
		logic [2:0] v;
		logic [3:0] blk;
		r  = '0;
		pg = a.page_number;
		if (!pt_present[pg]) begin
			v   = frame_page[fifo_ptr];
			blk = pt_block[v];
			r.write_back   = pt_dirty[v];
			pt_present[v]  = 1'b0;
			pt_block[v]    = 4'd0;
			pt_dirty[v]    = 1'b0;
			frame_page[fifo_ptr] = pg;
			pt_present[pg] = 1'b1;
			pt_block[pg]   = blk;
			fifo_ptr       = fifo_ptr + 2'd1;
			r.page_fault   = 1'b1;
			r.victim_page  = v;
		end
		if (a.is_store)
			pt_dirty[pg] = 1'b1;
		r.physical_address = {pt_block[pg], a.unit_offset};
		return r;
	endfunction

	function automatic stim_row_t row(int pg, int off, bit st, bit typed = 0,
			bit f = 0, int v = 0, bit wb = 0, int addr = 0);
		stim_row_t s;
		s.acc.page_number       = 3'(pg);
		s.acc.unit_offset       = 7'(off);
		s.acc.is_store          = st;
		s.typed                 = typed;
		s.want.page_fault       = f;
		s.want.victim_page      = 3'(v);
		s.want.write_back       = wb;
		s.want.physical_address = 11'(addr);
		return s;
	endfunction

	task automatic send_access(in_item_t a, bit typed, out_item_t want);
		out_item_t p;
		int        gap;
		in_valid <= 1'b1;
		in_item  <= a;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		p = translate_access(a);
		translations_due.insert(translations_due.size(), typed ? want : p);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = idle_off ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic report(string field, int want, int got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk) begin
		out_item_t w;
		if (arst_n && out_valid && out_ready) begin
			if (translations_due.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual %h", $time, out_item);
				mismatches++;
			end else begin
				w = translations_due.pop_front();
				if (out_item.page_fault !== w.page_fault)
					report("page_fault", w.page_fault, out_item.page_fault);
				if (out_item.victim_page !== w.victim_page)
					report("victim_page", w.victim_page, out_item.victim_page);
				if (out_item.write_back !== w.write_back)
					report("write_back", w.write_back, out_item.write_back);
				if (out_item.physical_address !== w.physical_address)
					report("physical_address", w.physical_address, out_item.physical_address);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random ready density per stretch, one long hold-off
	initial begin
		int  len;
		int  pct;
		int  rx_cycles;
		bit  held;
		out_ready = 1'b0;
		rx_cycles = 0;
		held      = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && rx_cycles > HOLD_START) begin
				held = 1'b1;
				repeat (HOLD_LEN) begin
					@(posedge clk);
					out_ready <= 1'b0;
				end
			end
			len = $urandom_range(5, 60);
			case ($urandom_range(0, 3))
				0:       pct = 100;
				1:       pct = 70;
				2:       pct = 30;
				default: pct = 90;
			endcase
			repeat (len) begin
				@(posedge clk);
				out_ready <= ($urandom_range(0, 99) < pct);
				rx_cycles++;
			end
		end
	end

	initial begin
		in_item_t  a;
		logic [2:0] base;
		bit        wide;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_item    = '0;
		mismatches = 0;
		cycles     = 0;
		idle_off   = 1'b0;
		burst_left = $urandom_range(1, 24);
		reset_tables();

		stim_table = '{
			row(0, 0,   0, 1, 0, 0, 0, 640),
			row(1, 127, 1, 1, 0, 0, 0, 1151),
			row(2, 127, 0, 1, 0, 0, 0, 1279),
			row(3, 0,   1, 1, 0, 0, 0, 128),
			row(4, 0,   0, 1, 1, 0, 0, 640),
			row(5, 127, 1, 1, 1, 1, 1, 1151),
			row(6, 85,  0),
			row(7, 42,  1),
			row(7, 127, 0),
			row(0, 1,   1),
			row(4, 0,   0),
			row(0, 127, 0),
			row(6, 64,  1),
			row(1, 3,   0),
			row(2, 126, 1),
			row(3, 0,   0),
			row(5, 127, 1),
			row(4, 96,  0),
			row(7, 31,  1),
			row(6, 0,   0)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i])
			send_access(stim_table[i].acc, stim_table[i].typed, stim_table[i].want);

		for (int ph = 0; ph < 7; ph++) begin
			idle_off = (ph == 2);
			if (ph == 4) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (translations_due.size() != 0) @(posedge clk);
			end
			base = 3'($urandom_range(0, 7));
			wide = (ph % 2 == 0);
			repeat (250) begin
				a.page_number = wide ? 3'($urandom_range(0, 7))
				                     : base + 3'($urandom_range(0, 4));
				a.unit_offset = 7'($urandom_range(0, 127));
				a.is_store    = 1'($urandom_range(0, 1));
				send_access(a, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (translations_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
